### hw/rtl/pncv_pkg.sv
// pncv_pkg: shared types and constants of the point/normal consensus vote block
// no dependencies
package pncv_pkg;

    localparam int MAX_OBSERVATIONS_DEF = 64;

    // configuration register indexes
    localparam logic [1:0] CFG_POINT_DIST = 2'd0;
    localparam logic [1:0] CFG_LAND_DIST  = 2'd1;
    localparam logic [1:0] CFG_COS_ANGLE  = 2'd2;

    localparam logic [62:0] POINT_DIST_RST = 63'd42949673;
    localparam logic [62:0] LAND_DIST_RST  = 63'd4294967296;
    localparam logic [28:0] COS_ANGLE_RST  = 29'd189812531;

    localparam logic [5:0] SUPPORT_MAX = 6'd63;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] landmark_x;
        logic signed [31:0] landmark_y;
        logic signed [31:0] landmark_z;
        logic               group_last;
    } in_t;

    typedef struct packed {
        logic               accepted;
        logic signed [31:0] best_point_x;
        logic signed [31:0] best_point_y;
        logic signed [31:0] best_point_z;
        logic signed [15:0] best_normal_x;
        logic signed [15:0] best_normal_y;
        logic signed [15:0] best_normal_z;
        logic        [5:0]  support_count;
        logic               overflowed;
    } out_t;

    // one stored observation
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
    } obs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_I,
        ST_LATCH_I,
        ST_SCAN,
        ST_DRAIN,
        ST_LAND,
        ST_LAND_WAIT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic land_load;  // latch landmark from input beat
        logic latch_cur;  // take ram data as reference observation
        logic scan;       // ram data of this read enters the pair pipe
        logic skip;       // pair is the reference with itself
        logic land;       // run best point against landmark
        logic commit;     // fold support count into best
        logic first;      // first reference of the group
        logic finish;     // load result register
        logic ovf;        // group overflowed
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic busy;
        logic out_full;
    } status_t;

endpackage

### hw/rtl/point_normal_consensus_vote_core.sv
// point_normal_consensus_vote_core: top level, observation ram, sequencer, datapath
// depends on pncv_pkg, pncv_ram, pncv_ctrl, pncv_dp
//
// channel   direction  handshake            beat
// in        in         in_valid/in_stall    pncv_pkg::in_t
// out       out        out_valid/out_stall  pncv_pkg::out_t
// cfg       in         cfg_we               cfg_index, cfg_wdata
//
// a beat without group_last is taken while idle and stored in the observation ram
// or, if it is full, only flags overflow; a beat with group_last is stored likewise
// and starts the vote over the n stored observations; the input then stalls while
// each reference scans the single read port and the three-stage pair pipe drains
// the final step of a vote also waits while an earlier result is still held
// reset clears counts and flags; the ram needs no clearing
module point_normal_consensus_vote_core #(
    parameter int MAX_OBSERVATIONS = pncv_pkg::MAX_OBSERVATIONS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pncv_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output pncv_pkg::out_t out_data,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [62:0]    cfg_wdata
);

    localparam int AW = $clog2(MAX_OBSERVATIONS);

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    pncv_pkg::obs_t    wr_obs;
    pncv_pkg::obs_t    rd_obs;
    pncv_pkg::cmd_t    cmd;
    pncv_pkg::status_t status;

    // observation word from the input beat
    always_comb
    begin
        wr_obs.px = in_data.point_x;
        wr_obs.py = in_data.point_y;
        wr_obs.pz = in_data.point_z;
        wr_obs.nx = in_data.normal_x;
        wr_obs.ny = in_data.normal_y;
        wr_obs.nz = in_data.normal_z;
    end

    pncv_ram #(
        .WIDTH ($bits(pncv_pkg::obs_t)),
        .DEPTH (MAX_OBSERVATIONS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_obs),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_obs)
    );

    pncv_ctrl #(
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .group_last (in_data.group_last),
        .in_stall   (in_stall),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .cmd        (cmd),
        .status     (status)
    );

    pncv_dp #(
        .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .rd_data   (rd_obs),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### hw/rtl/pncv_ram.sv
// pncv_ram: generic single-write, single-read ram with registered read
// no dependencies
module pncv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/pncv_ctrl.sv
// pncv_ctrl: sequencer of loading, pairwise scan, landmark test and result
// depends on pncv_pkg
module pncv_ctrl #(
    parameter int MAX_OBSERVATIONS = pncv_pkg::MAX_OBSERVATIONS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                group_last,
    output logic                                in_stall,
    output logic                                wr_en,
    output logic [$clog2(MAX_OBSERVATIONS)-1:0] wr_addr,
    output logic                                rd_en,
    output logic [$clog2(MAX_OBSERVATIONS)-1:0] rd_addr,
    output pncv_pkg::cmd_t                      cmd,
    input  pncv_pkg::status_t                   status
);

    localparam int AW = $clog2(MAX_OBSERVATIONS);
    localparam int CW = $clog2(MAX_OBSERVATIONS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_OBSERVATIONS);

    pncv_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic          ovf_reg, ovf_next;
    logic          accept;
    logic [CW-1:0] last_idx;

    assign accept   = in_valid && !in_stall;
    assign last_idx = cnt_reg - CW'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pncv_pkg::ST_IDLE:
            begin
                if (accept && group_last)
                begin
                    state_next = pncv_pkg::ST_READ_I;
                end
            end
            pncv_pkg::ST_READ_I:    state_next = pncv_pkg::ST_LATCH_I;
            pncv_pkg::ST_LATCH_I:   state_next = pncv_pkg::ST_SCAN;
            pncv_pkg::ST_SCAN:
            begin
                if (j_reg == last_idx)
                begin
                    state_next = pncv_pkg::ST_DRAIN;
                end
            end
            pncv_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = (i_reg == last_idx) ? pncv_pkg::ST_LAND
                                                     : pncv_pkg::ST_READ_I;
                end
            end
            pncv_pkg::ST_LAND:      state_next = pncv_pkg::ST_LAND_WAIT;
            pncv_pkg::ST_LAND_WAIT:
            begin
                if (!status.busy)
                begin
                    state_next = pncv_pkg::ST_DONE;
                end
            end
            pncv_pkg::ST_DONE:
            begin
                if (!status.out_full)
                begin
                    state_next = pncv_pkg::ST_IDLE;
                end
            end
            default:                state_next = pncv_pkg::ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        in_stall = 1'b1;
        wr_en    = 1'b0;
        wr_addr  = cnt_reg[AW-1:0];
        rd_en    = 1'b0;
        rd_addr  = i_reg[AW-1:0];
        cmd      = '0;
        cmd.ovf  = ovf_reg;
        cnt_next = cnt_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        ovf_next = ovf_reg;
        case (state_reg)
            pncv_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    if (cnt_reg == CNT_FULL)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    cmd.land_load = group_last;
                    i_next        = '0;
                end
            end
            pncv_pkg::ST_READ_I:
            begin
                rd_en = 1'b1;
            end
            pncv_pkg::ST_LATCH_I:
            begin
                cmd.latch_cur = 1'b1;
                j_next        = '0;
            end
            pncv_pkg::ST_SCAN:
            begin
                rd_en    = 1'b1;
                rd_addr  = j_reg[AW-1:0];
                cmd.scan = 1'b1;
                cmd.skip = (j_reg == i_reg);
                j_next   = j_reg + CW'(1);
            end
            pncv_pkg::ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    cmd.commit = 1'b1;
                    cmd.first  = (i_reg == '0);
                    i_next     = i_reg + CW'(1);
                end
            end
            pncv_pkg::ST_LAND:
            begin
                cmd.land = 1'b1;
            end
            pncv_pkg::ST_LAND_WAIT:
            begin
            end
            pncv_pkg::ST_DONE:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pncv_pkg::ST_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

### hw/rtl/pncv_dp.sv
// pncv_dp: pair pipe (distance and normal agreement), best pick, result register
// depends on pncv_pkg
module pncv_dp #(
    parameter int MAX_OBSERVATIONS = pncv_pkg::MAX_OBSERVATIONS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [62:0]       cfg_wdata,
    input  pncv_pkg::in_t     in_data,
    input  pncv_pkg::obs_t    rd_data,
    input  pncv_pkg::cmd_t    cmd,
    output pncv_pkg::status_t status,
    output logic              out_valid,
    input  logic              out_stall,
    output pncv_pkg::out_t    out_data
);

    localparam int CW = $clog2(MAX_OBSERVATIONS + 1);

    logic [62:0] point_thr_reg;
    logic [62:0] land_thr_reg;
    logic [28:0] cos_reg;

    logic signed [31:0] lm_x_reg, lm_y_reg, lm_z_reg;
    pncv_pkg::obs_t cur_reg;
    pncv_pkg::obs_t best_reg;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  best_cnt_reg;
    logic           acc_reg;

    // pipe valid and tags
    logic v0_reg, v1_reg, v2_reg;
    logic skip0_reg, skip1_reg, skip2_reg;
    logic land0_reg, land1_reg, land2_reg;

    // stage 1 registers
    logic [31:0] ax_reg, ay_reg, az_reg;
    logic        big_reg;
    logic signed [15:0] na_x_reg, na_y_reg, na_z_reg;
    logic signed [15:0] nb_x_reg, nb_y_reg, nb_z_reg;

    // stage 2 registers
    logic [63:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic        big2_reg;
    logic signed [31:0] dp_x_reg, dp_y_reg, dp_z_reg;

    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
    logic signed [32:0] d_x, d_y, d_z;
    logic [32:0]        m_x, m_y, m_z;
    logic [65:0]        dist_sum;
    logic [62:0]        dist_sat;
    logic signed [33:0] dot_sum;
    logic               pt_ok, land_ok, dot_ok;
    logic [CW+5:0]      bc_ext;

    // operand select and absolute differences
    always_comb
    begin
        a_x = land0_reg ? best_reg.px : cur_reg.px;
        a_y = land0_reg ? best_reg.py : cur_reg.py;
        a_z = land0_reg ? best_reg.pz : cur_reg.pz;
        b_x = land0_reg ? lm_x_reg : rd_data.px;
        b_y = land0_reg ? lm_y_reg : rd_data.py;
        b_z = land0_reg ? lm_z_reg : rd_data.pz;
        d_x = 33'(a_x) - 33'(b_x);
        d_y = 33'(a_y) - 33'(b_y);
        d_z = 33'(a_z) - 33'(b_z);
        m_x = d_x[32] ? 33'(-d_x) : 33'(d_x);
        m_y = d_y[32] ? 33'(-d_y) : 33'(d_y);
        m_z = d_z[32] ? 33'(-d_z) : 33'(d_z);
    end

    // stage 3 compare, distance saturated to 63 bits
    always_comb
    begin
        dist_sum = {2'b0, sq_x_reg} + {2'b0, sq_y_reg} + {2'b0, sq_z_reg};
        dist_sat = (big2_reg || (dist_sum[65:63] != 3'b0)) ? 63'h7FFF_FFFF_FFFF_FFFF
                                                           : dist_sum[62:0];
        dot_sum  = 34'(dp_x_reg) + 34'(dp_y_reg) + 34'(dp_z_reg);
        pt_ok    = dist_sat <= point_thr_reg;
        land_ok  = dist_sat <= land_thr_reg;
        dot_ok   = dot_sum >= $signed({5'b0, cos_reg});
        bc_ext   = {6'b0, best_cnt_reg};
    end

    assign status.busy     = v0_reg || v1_reg || v2_reg;
    assign status.out_full = out_valid;

    // configuration registers and valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_thr_reg <= pncv_pkg::POINT_DIST_RST;
            land_thr_reg  <= pncv_pkg::LAND_DIST_RST;
            cos_reg       <= pncv_pkg::COS_ANGLE_RST;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    pncv_pkg::CFG_POINT_DIST: point_thr_reg <= cfg_wdata;
                    pncv_pkg::CFG_LAND_DIST:  land_thr_reg  <= cfg_wdata;
                    pncv_pkg::CFG_COS_ANGLE:  cos_reg       <= cfg_wdata[28:0];
                    default:
                    begin
                    end
                endcase
            end
            v0_reg <= cmd.scan || cmd.land;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            if (cmd.finish)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // pipe payload, best tracking and result
    always_ff @(posedge clk)
    begin
        skip0_reg <= cmd.skip;
        land0_reg <= cmd.land;
        skip1_reg <= skip0_reg;
        land1_reg <= land0_reg;
        skip2_reg <= skip1_reg;
        land2_reg <= land1_reg;

        ax_reg   <= m_x[31:0];
        ay_reg   <= m_y[31:0];
        az_reg   <= m_z[31:0];
        big_reg  <= m_x[32] || m_y[32] || m_z[32];
        na_x_reg <= cur_reg.nx;
        na_y_reg <= cur_reg.ny;
        na_z_reg <= cur_reg.nz;
        nb_x_reg <= rd_data.nx;
        nb_y_reg <= rd_data.ny;
        nb_z_reg <= rd_data.nz;

        sq_x_reg <= {32'b0, ax_reg} * {32'b0, ax_reg};
        sq_y_reg <= {32'b0, ay_reg} * {32'b0, ay_reg};
        sq_z_reg <= {32'b0, az_reg} * {32'b0, az_reg};
        big2_reg <= big_reg;
        dp_x_reg <= 32'(na_x_reg) * 32'(nb_x_reg);
        dp_y_reg <= 32'(na_y_reg) * 32'(nb_y_reg);
        dp_z_reg <= 32'(na_z_reg) * 32'(nb_z_reg);

        if (cmd.land_load)
        begin
            lm_x_reg <= in_data.landmark_x;
            lm_y_reg <= in_data.landmark_y;
            lm_z_reg <= in_data.landmark_z;
        end
        if (cmd.latch_cur)
        begin
            cur_reg <= rd_data;
            cnt_reg <= '0;
        end
        else if (v2_reg && !land2_reg && !skip2_reg && pt_ok && dot_ok)
        begin
            cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.commit && (cmd.first || cnt_reg > best_cnt_reg))
        begin
            best_reg     <= cur_reg;
            best_cnt_reg <= cnt_reg;
        end
        if (v2_reg && land2_reg)
        begin
            acc_reg <= land_ok;
        end
        if (cmd.finish)
        begin
            out_data.accepted      <= acc_reg;
            out_data.best_point_x  <= best_reg.px;
            out_data.best_point_y  <= best_reg.py;
            out_data.best_point_z  <= best_reg.pz;
            out_data.best_normal_x <= best_reg.nx;
            out_data.best_normal_y <= best_reg.ny;
            out_data.best_normal_z <= best_reg.nz;
            out_data.support_count <= (bc_ext > (CW+6)'(pncv_pkg::SUPPORT_MAX))
                                      ? pncv_pkg::SUPPORT_MAX : bc_ext[5:0];
            out_data.overflowed    <= cmd.ovf;
        end
    end

endmodule

### hw/rtl/pncv_checker.sv
// pncv_checker: port-level checks of the consensus vote top level, bound to it
// depends on pncv_pkg and point_normal_consensus_vote_core
module pncv_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input pncv_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input pncv_pkg::out_t out_data
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // a group-closing beat starts the vote, input stalls next
    a_vote_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.group_last |=> in_stall)
        else $error("input taken during vote");

    // a new result never appears while input is open
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised outside vote");

endmodule

bind point_normal_consensus_vote_core pncv_checker u_pncv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
